### sv/msmt_pkg.sv
package msmt_pkg;

    // Geometry of the tested region and of the modulo stride
    localparam int ADDR_WIDTH = 28;
    localparam int STRIDE     = 20;
    localparam int PTR_W      = ADDR_WIDTH + 1;
    localparam int OFF_W      = 5;
    localparam int WC_W       = 29;
    localparam int PAT_W      = 64;
    localparam int RPT_W      = 8;
    localparam int ERR_W      = 32;
    localparam int CMD_W      = 2;
    localparam int PH_W       = 2;

    // Largest region size in words
    localparam logic [PTR_W-1:0] REGION_MAX = {1'b1, {ADDR_WIDTH{1'b0}}};

    // Test phases
    localparam logic [PH_W-1:0] PH_FILL    = 2'd0;
    localparam logic [PH_W-1:0] PH_DISTURB = 2'd1;
    localparam logic [PH_W-1:0] PH_VERIFY  = 2'd2;
    localparam logic [PH_W-1:0] PH_DONE    = 2'd3;

    // Memory commands
    localparam logic [CMD_W-1:0] CMD_NOP      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FINISHED = 2'd3;

    localparam logic [RPT_W-1:0] DEFAULT_REPEATS = 8'd3;

    // Configuration register map (8-byte spacing)
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_PATTERN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WORD_COUNT   = 2'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 168;

    typedef struct packed {
        logic [PAT_W-1:0] read_data;
        logic             abort;
    } t_item;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [ADDR_WIDTH-1:0] address;
        logic [PAT_W-1:0]      write_data;
        logic                  checked;
        logic                  mismatch;
        logic [ADDR_WIDTH-1:0] checked_address;
        logic [ERR_W-1:0]      error_count;
        logic                  pass_polarity;
        logic [OFF_W-1:0]      pass_offset;
    } t_result;

    typedef struct packed {
        logic [PAT_W-1:0] base_pattern;
        logic [RPT_W-1:0] repeat_count;
        logic [WC_W-1:0]  word_count;
    } t_cfg;

endpackage

### sv/modulo_stride_memory_test_sequencer.sv
// Modulo-20 memory test sequencer: one memory command per accepted transaction.
// An accepted transaction waits in the input register for the result register.
// Throughput: one transaction per cycle unless the master side stalls; the input
// and result registers decouple the stream sides; sequencer state advances once per step.
// Reset (i_rst_n low, synchronous) clears the sequence state, the error count and
// the registers; word_count resets to 1.
module modulo_stride_memory_test_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // read_data[63:0], abort[64], zero pad[71:65]
    input  logic [msmt_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // command[1:0], address[29:2], write_data[93:30], checked[94], mismatch[95],
    // checked_address[123:96], error_count[155:124], pass_polarity[156],
    // pass_offset[161:157], zero pad[167:162]
    output logic [msmt_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msmt_pkg::PADDR_W-1:0]       paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    localparam int OUT_PAD = msmt_pkg::OUT_TDATA_W - $bits(msmt_pkg::t_result);

    logic              r_in_valid;
    msmt_pkg::t_item   r_in_item;
    logic              r_out_valid;
    msmt_pkg::t_result r_out;
    logic              advance;
    msmt_pkg::t_cfg    cfg;
    msmt_pkg::t_result step_res;

    msmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msmt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // Step when an item is held and the result register can take it
    assign advance    = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | advance;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.read_data <= i_s_tdata[msmt_pkg::PAT_W-1:0];
            r_in_item.abort     <= i_s_tdata[msmt_pkg::PAT_W];
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD{1'b0}}, r_out.pass_offset, r_out.pass_polarity,
                         r_out.error_count, r_out.checked_address, r_out.mismatch,
                         r_out.checked, r_out.write_data, r_out.address, r_out.command};

endmodule

### sv/msmt_cfg.sv
module msmt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msmt_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output msmt_pkg::t_cfg                o_cfg
);

    logic [msmt_pkg::PAT_W-1:0]     r_base_pattern;
    logic [msmt_pkg::RPT_W-1:0]     r_repeat_count;
    logic [msmt_pkg::WC_W-1:0]      r_word_count;
    logic [msmt_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[msmt_pkg::PADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pattern <= '0;
            r_repeat_count <= '0;
            r_word_count   <= msmt_pkg::WC_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                msmt_pkg::REG_BASE_PATTERN: r_base_pattern <= pwdata;
                msmt_pkg::REG_REPEAT_COUNT: r_repeat_count <= pwdata[msmt_pkg::RPT_W-1:0];
                msmt_pkg::REG_WORD_COUNT:   r_word_count   <= pwdata[msmt_pkg::WC_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            msmt_pkg::REG_BASE_PATTERN: prdata = r_base_pattern;
            msmt_pkg::REG_REPEAT_COUNT: prdata = 64'(r_repeat_count);
            msmt_pkg::REG_WORD_COUNT:   prdata = 64'(r_word_count);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.base_pattern = r_base_pattern;
    assign o_cfg.repeat_count = r_repeat_count;
    assign o_cfg.word_count   = r_word_count;

endmodule

### sv/msmt_seq.sv
module msmt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  msmt_pkg::t_item   i_item,
    input  msmt_pkg::t_cfg    i_cfg,
    output msmt_pkg::t_result o_result
);

    logic                             r_polarity, n_polarity;
    logic [msmt_pkg::OFF_W-1:0]       r_offset, n_offset;
    logic [msmt_pkg::PH_W-1:0]        r_phase, n_phase;
    logic [msmt_pkg::RPT_W-1:0]       r_repeats, n_repeats;
    logic [msmt_pkg::PTR_W-1:0]       r_ptr, n_ptr;
    logic [msmt_pkg::OFF_W-1:0]       r_residue, n_residue;
    logic                             r_read_pending, n_read_pending;
    logic [msmt_pkg::ADDR_WIDTH-1:0]  r_pend_addr, n_pend_addr;
    logic                             r_pend_prot, n_pend_prot;
    logic [msmt_pkg::ERR_W-1:0]       r_err, n_err;

    logic [msmt_pkg::PTR_W-1:0]       region;
    logic [msmt_pkg::OFF_W:0]         off_inc;
    logic                             off_ge_lim;
    logic                             off_next_ok;
    logic [msmt_pkg::PAT_W-1:0]       chk_pat;
    logic [msmt_pkg::PAT_W-1:0]       exp_data;
    logic [msmt_pkg::PAT_W-1:0]       iss_pat;
    logic [msmt_pkg::RPT_W-1:0]       rep_dec;
    logic                             prot;
    msmt_pkg::t_result                res;

    // Clamp the live word count to the address space
    assign region = (msmt_pkg::PTR_W'(i_cfg.word_count) > msmt_pkg::REGION_MAX) ?
                    msmt_pkg::REGION_MAX : msmt_pkg::PTR_W'(i_cfg.word_count);

    // Offset limits against min(stride, words)
    assign off_inc     = {1'b0, r_offset} + (msmt_pkg::OFF_W+1)'(1);
    assign off_ge_lim  = (r_offset >= msmt_pkg::OFF_W'(msmt_pkg::STRIDE)) ||
                         (msmt_pkg::PTR_W'(r_offset) >= region);
    assign off_next_ok = (off_inc < (msmt_pkg::OFF_W+1)'(msmt_pkg::STRIDE)) &&
                         (msmt_pkg::PTR_W'(off_inc) < region);

    assign chk_pat  = r_polarity ? ~i_cfg.base_pattern : i_cfg.base_pattern;
    assign exp_data = r_pend_prot ? chk_pat : ~chk_pat;
    assign rep_dec  = (r_repeats != '0) ? r_repeats - msmt_pkg::RPT_W'(1) : r_repeats;

    // One step: compare pending read, advance phase, issue command
    always_comb begin
        n_polarity     = r_polarity;
        n_offset       = r_offset;
        n_phase        = r_phase;
        n_repeats      = r_repeats;
        n_ptr          = r_ptr;
        n_residue      = r_residue;
        n_read_pending = 1'b0;
        n_pend_addr    = r_pend_addr;
        n_pend_prot    = r_pend_prot;
        n_err          = r_err;
        res            = '0;
        res.command    = msmt_pkg::CMD_FINISHED;

        // Compare the word returned for the previous read
        if (r_read_pending) begin
            res.checked         = 1'b1;
            res.checked_address = r_pend_addr;
            if (i_item.read_data != exp_data) begin
                res.mismatch = 1'b1;
                if (r_err != '1) begin
                    n_err = r_err + msmt_pkg::ERR_W'(1);
                end
            end
        end

        if (i_item.abort) begin
            n_phase = msmt_pkg::PH_DONE;
        end

        // Close a finished phase and move to the next one
        if (n_phase != msmt_pkg::PH_DONE) begin
            if (off_ge_lim) begin
                n_phase = msmt_pkg::PH_DONE;
            end else if (r_ptr >= region) begin
                n_ptr     = '0;
                n_residue = '0;
                case (r_phase)
                    msmt_pkg::PH_FILL: begin
                        n_repeats = (i_cfg.repeat_count != '0) ? i_cfg.repeat_count :
                                    msmt_pkg::DEFAULT_REPEATS;
                        n_phase   = msmt_pkg::PH_DISTURB;
                    end
                    msmt_pkg::PH_DISTURB: begin
                        n_repeats = rep_dec;
                        if (rep_dec == '0) begin
                            n_phase = msmt_pkg::PH_VERIFY;
                        end
                    end
                    msmt_pkg::PH_VERIFY: begin
                        n_phase = msmt_pkg::PH_FILL;
                        if (off_next_ok) begin
                            n_offset = off_inc[msmt_pkg::OFF_W-1:0];
                        end else if (!r_polarity) begin
                            n_polarity = 1'b1;
                            n_offset   = '0;
                        end else begin
                            n_phase = msmt_pkg::PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        iss_pat = n_polarity ? ~i_cfg.base_pattern : i_cfg.base_pattern;
        prot    = (n_residue == n_offset);

        // Issue the memory command for the current word
        if (n_phase != msmt_pkg::PH_DONE) begin
            res.address = n_ptr[msmt_pkg::ADDR_WIDTH-1:0];
            case (n_phase)
                msmt_pkg::PH_FILL: begin
                    res.command    = msmt_pkg::CMD_WRITE;
                    res.write_data = iss_pat;
                end
                msmt_pkg::PH_DISTURB: begin
                    if (prot) begin
                        res.command = msmt_pkg::CMD_NOP;
                    end else begin
                        res.command    = msmt_pkg::CMD_WRITE;
                        res.write_data = ~iss_pat;
                    end
                end
                msmt_pkg::PH_VERIFY: begin
                    res.command    = msmt_pkg::CMD_READ;
                    n_read_pending = 1'b1;
                    n_pend_addr    = n_ptr[msmt_pkg::ADDR_WIDTH-1:0];
                    n_pend_prot    = prot;
                end
                default: ;
            endcase
            n_ptr     = n_ptr + msmt_pkg::PTR_W'(1);
            n_residue = (n_residue == msmt_pkg::OFF_W'(msmt_pkg::STRIDE - 1)) ?
                        '0 : n_residue + msmt_pkg::OFF_W'(1);
        end

        res.error_count   = n_err;
        res.pass_polarity = n_polarity;
        res.pass_offset   = n_offset;
    end

    assign o_result = res;

    // Hold the sequencer state between steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity     <= 1'b0;
            r_offset       <= '0;
            r_phase        <= msmt_pkg::PH_FILL;
            r_repeats      <= '0;
            r_ptr          <= '0;
            r_residue      <= '0;
            r_read_pending <= 1'b0;
            r_pend_addr    <= '0;
            r_pend_prot    <= 1'b0;
            r_err          <= '0;
        end else if (i_step) begin
            r_polarity     <= n_polarity;
            r_offset       <= n_offset;
            r_phase        <= n_phase;
            r_repeats      <= n_repeats;
            r_ptr          <= n_ptr;
            r_residue      <= n_residue;
            r_read_pending <= n_read_pending;
            r_pend_addr    <= n_pend_addr;
            r_pend_prot    <= n_pend_prot;
            r_err          <= n_err;
        end
    end

`ifndef SYNTH
    a_offset_in_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != msmt_pkg::PH_DONE) |-> (r_offset < msmt_pkg::OFF_W'(msmt_pkg::STRIDE)))
        else $error("offset beyond stride while test runs");
    a_residue_in_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_residue < msmt_pkg::OFF_W'(msmt_pkg::STRIDE))
        else $error("pointer residue out of range");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == msmt_pkg::PH_DONE) |=> (r_phase == msmt_pkg::PH_DONE))
        else $error("left finished state without reset");
    a_pending_in_verify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_pending |-> (r_phase == msmt_pkg::PH_VERIFY))
        else $error("read pending outside verify phase");
    a_disturb_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == msmt_pkg::PH_DISTURB) |-> (r_repeats != '0))
        else $error("disturb phase with no passes left");
`endif

endmodule

### test/msmt_checker.sv
module msmt_checker
    import msmt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // read_data[63:0], abort[64], zero pad[71:65]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // command[1:0], address[29:2], write_data[93:30], checked[94], mismatch[95],
    // checked_address[123:96], error_count[155:124], pass_polarity[156],
    // pass_offset[161:157], zero pad[167:162]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [63:0]            i_pwdata,
    input  logic [63:0]            i_prdata,
    output int                     o_fail_count,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the configuration registers
    logic [PAT_W-1:0]  reg_pattern;
    logic [RPT_W-1:0]  reg_repeats;
    logic [WC_W-1:0]   reg_words;

    // Shadow of the sequencer state
    logic              seq_polarity;
    logic [OFF_W-1:0]  seq_offset;
    logic [PH_W-1:0]   seq_phase;
    logic [RPT_W-1:0]  seq_repeats_left;
    logic [PTR_W-1:0]  seq_pointer;
    logic [OFF_W-1:0]  seq_residue;
    logic              rd_pending;
    logic [ADDR_WIDTH-1:0] rd_address;
    logic              rd_protected;
    logic [ERR_W-1:0]  mismatch_total;

    t_result expected_commands[$];
    int      errors_seen = 0;

    assign o_fail_count = errors_seen;

    task automatic flag_error(input string field, input logic [63:0] got,
                              input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        errors_seen++;
    endtask

    // Walk through completed phases until a command can be issued or the test ends
    function automatic void settle_sequence();
        logic [PTR_W-1:0] region;
        int               lim;
        for (int g = 0; g < 8; g++) begin
            if (seq_phase == PH_DONE)
                return;
            region = (reg_words > REGION_MAX) ? REGION_MAX : reg_words;
            lim = (region < STRIDE) ? int'(region) : STRIDE;
            if (int'(seq_offset) >= lim) begin
                seq_phase = PH_DONE;
                return;
            end
            if (seq_pointer < region)
                return;
            seq_pointer = '0;
            seq_residue = '0;
            case (seq_phase)
                PH_FILL: begin
                    seq_repeats_left = (reg_repeats != '0) ? reg_repeats : DEFAULT_REPEATS;
                    seq_phase = PH_DISTURB;
                end
                PH_DISTURB: begin
                    if (seq_repeats_left != '0)
                        seq_repeats_left--;
                    if (seq_repeats_left == '0)
                        seq_phase = PH_VERIFY;
                end
                default: begin
                    seq_phase = PH_FILL;
                    if (int'(seq_offset) + 1 < lim) begin
                        seq_offset++;
                    end else if (!seq_polarity) begin
                        seq_polarity = 1'b1;
                        seq_offset = '0;
                    end else begin
                        seq_phase = PH_DONE;
                        return;
                    end
                end
            endcase
        end
    endfunction

    // Compute the memory command answering one input transaction
    function automatic t_result next_memory_command(input logic [PAT_W-1:0] rdata,
                                                    input logic abort_in);
        t_result          r;
        logic [PAT_W-1:0] pat;
        logic             prot;
        r = '0;
        r.command = CMD_FINISHED;
        // compare the word returned for the previous read
        if (rd_pending) begin
            pat = seq_polarity ? ~reg_pattern : reg_pattern;
            r.checked = 1'b1;
            r.checked_address = rd_address;
            if (rdata != (rd_protected ? pat : ~pat)) begin
                r.mismatch = 1'b1;
                if (mismatch_total != '1)
                    mismatch_total++;
            end
            rd_pending = 1'b0;
        end
        if (abort_in)
            seq_phase = PH_DONE;
        settle_sequence();
        if (seq_phase != PH_DONE) begin
            pat = seq_polarity ? ~reg_pattern : reg_pattern;
            prot = (seq_residue == seq_offset);
            r.address = seq_pointer[ADDR_WIDTH-1:0];
            case (seq_phase)
                PH_FILL: begin
                    r.command = CMD_WRITE;
                    r.write_data = pat;
                end
                PH_DISTURB: begin
                    if (prot) begin
                        r.command = CMD_NOP;
                    end else begin
                        r.command = CMD_WRITE;
                        r.write_data = ~pat;
                    end
                end
                default: begin
                    r.command = CMD_READ;
                    rd_pending = 1'b1;
                    rd_address = r.address;
                    rd_protected = prot;
                end
            endcase
            seq_pointer++;
            seq_residue = (int'(seq_residue) + 1 >= STRIDE) ? '0 : seq_residue + OFF_W'(1);
        end
        r.error_count = mismatch_total;
        r.pass_polarity = seq_polarity;
        r.pass_offset = seq_offset;
        return r;
    endfunction

    // Track register writes, predict on input transactions, compare on output ones
    always @(posedge i_clk) begin : watch
        t_result          got;
        t_result          want;
        logic [63:0]      reg_value;
        logic             push;
        logic             pop;
        push = 1'b0;
        pop = 1'b0;
        if (!i_rst_n) begin
            reg_pattern      = '0;
            reg_repeats      = '0;
            reg_words        = WC_W'(1);
            seq_polarity     = 1'b0;
            seq_offset       = '0;
            seq_phase        = PH_FILL;
            seq_repeats_left = '0;
            seq_pointer      = '0;
            seq_residue      = '0;
            rd_pending       = 1'b0;
            rd_address       = '0;
            rd_protected     = 1'b0;
            mismatch_total   = '0;
            expected_commands.delete();
            o_outstanding   <= 0;
        end else begin
            // register access
            if (i_psel && i_penable && i_pready) begin
                case (i_paddr[PADDR_W-1:3])
                    REG_BASE_PATTERN: reg_value = reg_pattern;
                    REG_REPEAT_COUNT: reg_value = 64'(reg_repeats);
                    default:          reg_value = 64'(reg_words);
                endcase
                if (!i_pwrite) begin
                    if (i_prdata != reg_value)
                        flag_error("register read", i_prdata, reg_value);
                end else begin
                    case (i_paddr[PADDR_W-1:3])
                        REG_BASE_PATTERN: reg_pattern = i_pwdata;
                        REG_REPEAT_COUNT: reg_repeats = i_pwdata[RPT_W-1:0];
                        REG_WORD_COUNT:   reg_words = i_pwdata[WC_W-1:0];
                        default: ;
                    endcase
                end
            end

            // result transaction
            if (i_m_tvalid && i_m_tready) begin
                got.command         = i_m_tdata[1:0];
                got.address         = i_m_tdata[29:2];
                got.write_data      = i_m_tdata[93:30];
                got.checked         = i_m_tdata[94];
                got.mismatch        = i_m_tdata[95];
                got.checked_address = i_m_tdata[123:96];
                got.error_count     = i_m_tdata[155:124];
                got.pass_polarity   = i_m_tdata[156];
                got.pass_offset     = i_m_tdata[161:157];
                if (expected_commands.size() == 0) begin
                    flag_error("unexpected result", 64'(got.command), 64'(CMD_FINISHED));
                end else begin
                    want = expected_commands.pop_front();
                    pop = 1'b1;
                    if (got.command != want.command)
                        flag_error("command", 64'(got.command), 64'(want.command));
                    if (got.address != want.address)
                        flag_error("address", 64'(got.address), 64'(want.address));
                    if (got.write_data != want.write_data)
                        flag_error("write_data", got.write_data, want.write_data);
                    if (got.checked != want.checked)
                        flag_error("checked", 64'(got.checked), 64'(want.checked));
                    if (got.mismatch != want.mismatch)
                        flag_error("mismatch", 64'(got.mismatch), 64'(want.mismatch));
                    if (got.checked_address != want.checked_address)
                        flag_error("checked_address", 64'(got.checked_address),
                                   64'(want.checked_address));
                    if (got.error_count != want.error_count)
                        flag_error("error_count", 64'(got.error_count),
                                   64'(want.error_count));
                    if (got.pass_polarity != want.pass_polarity)
                        flag_error("pass_polarity", 64'(got.pass_polarity),
                                   64'(want.pass_polarity));
                    if (got.pass_offset != want.pass_offset)
                        flag_error("pass_offset", 64'(got.pass_offset),
                                   64'(want.pass_offset));
                end
            end

            // input transaction
            if (i_s_tvalid && i_s_tready) begin
                expected_commands.push_back(
                    next_memory_command(i_s_tdata[PAT_W-1:0], i_s_tdata[PAT_W]));
                push = 1'b1;
            end
            o_outstanding <= o_outstanding + int'(push) - int'(pop);
        end
    end

endmodule

### test/tb_modulo_stride_memory_test_sequencer.sv
module tb_modulo_stride_memory_test_sequencer;
    import msmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [PAT_W-1:0] ALL_ONES = {PAT_W{1'b1}};

    // Read data for the short region: matches, misses and alternating bits
    localparam logic [0:17][PAT_W-1:0] SHORT_REGION_DATA = {
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [63:0]             pwdata;
    logic [63:0]             prdata;
    logic                    pready;

    int                      fail_total;
    int                      results_owed;
    int                      idle_cycles;
    logic [CMD_W-1:0]        last_command;
    logic [PAT_W-1:0]        cur_pattern;
    bit                      sender_quiet;
    bit                      sink_quiet = 1'b0;
    int                      sink_hold = 0;

    modulo_stride_memory_test_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    msmt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .o_fail_count  (fail_total),
        .o_outstanding (results_owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Favor the expected words so both matches and mismatches show up
    function automatic logic [PAT_W-1:0] pick_read_data();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return cur_pattern;
            4, 5, 6:    return ~cur_pattern;
            7:          return cur_pattern ^ (64'd1 << $urandom_range(0, 63));
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    // Stall the result side at random, with calm stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 149) == 0)
            sink_quiet = !sink_quiet;
        if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 3) == 0)
                sink_hold = draw_gap();
        end
    end

    // Remember the last command handed out
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            last_command <= o_m_tdata[CMD_W-1:0];
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_item(input logic [PAT_W-1:0] data, input logic abort_bit);
        int gap;
        if (!sender_quiet && $urandom_range(0, 2) == 0) begin
            gap = draw_gap();
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {{(IN_TDATA_W-PAT_W-1){1'b0}}, abort_bit, data};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer: setup cycle, then access cycle
    task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input logic write_en,
                              input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram all registers while idle, then read them back
    task automatic apply_settings(input logic [PAT_W-1:0] pattern,
                                  input logic [RPT_W-1:0] repeats,
                                  input logic [WC_W-1:0] words);
        logic [63:0] junk;
        wait_drained();
        junk = {$urandom, $urandom};
        reg_access(REG_BASE_PATTERN, 1'b1, pattern);
        reg_access(REG_REPEAT_COUNT, 1'b1, {junk[63:RPT_W], repeats});
        reg_access(REG_WORD_COUNT, 1'b1, {junk[63:WC_W], words});
        reg_access(REG_BASE_PATTERN, 1'b0, '0);
        reg_access(REG_REPEAT_COUNT, 1'b0, '0);
        reg_access(REG_WORD_COUNT, 1'b0, '0);
        cur_pattern = pattern;
        sender_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_items(input int count);
        repeat (count) send_item(pick_read_data(), 1'b0);
    endtask

    initial begin
        int tries;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        sender_quiet = 1'b0;
        cur_pattern  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single word: fill, three no-op disturb passes, one read, polarity flip
        apply_settings(ALL_ONES, 8'd0, WC_W'(1));
        for (int i = 0; i < 6; i++)
            send_item((i % 2) ? ALL_ONES : '0, 1'b0);

        // Three words, one disturb pass: walk two offsets with hits and misses
        apply_settings('0, 8'd1, WC_W'(3));
        for (int i = 0; i < 18; i++)
            send_item(SHORT_REGION_DATA[i], 1'b0);

        // Full stride, then a huge region, then shrink so the phase ends early
        apply_settings({$urandom, $urandom}, 8'd2, WC_W'(20));
        run_items(150);
        apply_settings(ALL_ONES, 8'd255, WC_W'(REGION_MAX));
        run_items(60);
        apply_settings({$urandom, $urandom}, 8'd1, WC_W'(12));
        run_items(120);
        apply_settings('0, 8'd0, WC_W'(20));
        run_items(100);
        apply_settings({$urandom, $urandom}, 8'd1, WC_W'(1000));
        run_items(150);

        // Step until a read is out, then abort with that read still pending
        apply_settings({$urandom, $urandom}, 8'd1, WC_W'(12));
        tries = 0;
        do begin
            send_item(pick_read_data(), 1'b0);
            wait_drained();
            tries++;
        end while (last_command != CMD_READ && last_command != CMD_FINISHED && tries < 64);
        send_item(pick_read_data(), 1'b1);

        // Finished state must hold through aborts and an empty region
        repeat (6) send_item({$urandom, $urandom}, 1'($urandom_range(0, 1)));
        apply_settings({$urandom, $urandom}, 8'd255, '0);
        run_items(4);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_total == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### modulo_stride_memory_test_sequencer.f
sv/msmt_pkg.sv
sv/msmt_cfg.sv
sv/msmt_seq.sv
sv/modulo_stride_memory_test_sequencer.sv
test/msmt_checker.sv
test/tb_modulo_stride_memory_test_sequencer.sv
